// File: rtl/tmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared constants, codes and controller/datapath interface types for the
// tape machine interpreter.
// ----------------------------------------------------------------------------
package tmi_pkg;

  localparam int PROGRAM_DEPTH = 1024;
  localparam int TAPE_DEPTH    = 32;

  localparam int ADDR_W   = $clog2(PROGRAM_DEPTH);
  localparam int PTR_W    = $clog2(PROGRAM_DEPTH + 1);
  localparam int CP_W     = $clog2(TAPE_DEPTH);
  localparam int CELL_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int PC_W     = 11;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_CHAR    = 3'd1,
    ST_ENDED   = 3'd2,
    ST_BRACKET = 3'd3,
    ST_BADCHAR = 3'd4,
    ST_FULL    = 3'd5,
    ST_IDLE    = 3'd6
  } status_t;

  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    CLS_INC,
    CLS_DEC,
    CLS_RIGHT,
    CLS_LEFT,
    CLS_OUT,
    CLS_IN,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_NOP,
    CLS_BAD
  } instr_t;

  typedef enum logic [1:0] {
    SCAN_CHECK,
    SCAN_FWD,
    SCAN_BACK
  } scan_t;

  typedef struct packed {
    logic  latch;
    logic  load_byte;
    logic  clr_run;
    logic  start_run;
    logic  fetch;
    logic  exec;
    logic  advance;
    logic  grab_char;
    logic  clr_char;
    logic  scan_init;
    logic  scan_en;
    scan_t scan_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic   full;
    logic   running;
    logic   at_end;
    logic   cell_zero;
    logic   ip_zero;
    logic   scan_done;
    logic   scan_ok;
    instr_t instr;
  } dp_stat_t;

  function automatic instr_t decode_instr(input logic [BYTE_W-1:0] c);
    instr_t cls;
    case (c)
      CH_PLUS:  cls = CLS_INC;
      CH_MINUS: cls = CLS_DEC;
      CH_RIGHT: cls = CLS_RIGHT;
      CH_LEFT:  cls = CLS_LEFT;
      CH_DOT:   cls = CLS_OUT;
      CH_COMMA: cls = CLS_IN;
      CH_OPEN:  cls = CLS_OPEN;
      CH_CLOSE: cls = CLS_CLOSE;
      CH_SPACE: cls = CLS_NOP;
      default:  cls = CLS_BAD;
    endcase
    return cls;
  endfunction

endpackage

// File: rtl/tmi_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_dpath
// Datapath: program memory, tape cells, pointers and the bracket scan unit.
// ----------------------------------------------------------------------------
module tmi_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmi_pkg::dp_cmd_t              cmd,
  output tmi_pkg::dp_stat_t             stat,
  input  logic [tmi_pkg::BYTE_W-1:0]    in_byte,
  input  logic [tmi_pkg::CELL_W-1:0]    in_value,
  output logic [tmi_pkg::BYTE_W-1:0]    char_out,
  output logic [tmi_pkg::PTR_W-1:0]     ip_out
);
  import tmi_pkg::*;

  logic [BYTE_W-1:0] prog_mem_r [PROGRAM_DEPTH];
  logic [BYTE_W-1:0] rdata_r;
  logic [ADDR_W-1:0] raddr;

  logic [CELL_W-1:0] tape_r [TAPE_DEPTH];
  logic [CP_W-1:0]   cp_r;
  logic [PTR_W-1:0]  len_r;
  logic [PTR_W-1:0]  ip_r;
  logic              run_r;

  logic [BYTE_W-1:0] byte_r;
  logic [CELL_W-1:0] value_r;
  logic [BYTE_W-1:0] char_r;

  // Scan unit: sa_r is the next address issued, sp_r the position whose byte
  // sits in rdata_r, sv_r marks that byte as belonging to the current scan.
  logic [PTR_W-1:0]  sa_r;
  logic [PTR_W-1:0]  sp_r;
  logic              sv_r;
  logic [PTR_W-1:0]  depth_r;
  logic [PTR_W-1:0]  depth_nxt;
  scan_t             skind_r;

  logic [CELL_W-1:0] cur_cell;
  instr_t            instr;
  logic              scan_done;
  logic              scan_ok;
  logic [PTR_W-1:0]  jump_ip;
  logic              past_end;
  logic              is_open;
  logic              is_close;
  logic              depth_zero;
  logic [PTR_W-1:0]  scan_start;

  assign cur_cell = tape_r[cp_r];
  assign instr    = decode_instr(rdata_r);
  assign raddr    = cmd.fetch ? ip_r[ADDR_W-1:0] : sa_r[ADDR_W-1:0];

  always_comb begin
    case (cmd.scan_kind)
      SCAN_FWD:  scan_start = ip_r + 1'b1;
      SCAN_BACK: scan_start = ip_r - 1'b1;
      default:   scan_start = '0;
    endcase
  end

  always_comb begin
    past_end   = (sp_r >= len_r);
    is_open    = (rdata_r == CH_OPEN);
    is_close   = (rdata_r == CH_CLOSE);
    depth_zero = (depth_r == '0);
    scan_done  = 1'b0;
    scan_ok    = 1'b0;
    jump_ip    = len_r;
    depth_nxt  = depth_r;
    if (cmd.scan_en && sv_r) begin
      case (skind_r)
        SCAN_CHECK: begin
          if (past_end) begin
            scan_done = 1'b1;
            scan_ok   = depth_zero;
          end else if (is_close && depth_zero) begin
            scan_done = 1'b1;
          end else if (is_open) begin
            depth_nxt = depth_r + 1'b1;
          end else if (is_close) begin
            depth_nxt = depth_r - 1'b1;
          end
        end
        SCAN_FWD: begin
          if (past_end) begin
            scan_done = 1'b1;
            jump_ip   = len_r;
          end else if (is_close && depth_zero) begin
            scan_done = 1'b1;
            jump_ip   = sp_r + 1'b1;
          end else if (is_open) begin
            depth_nxt = depth_r + 1'b1;
          end else if (is_close) begin
            depth_nxt = depth_r - 1'b1;
          end
        end
        SCAN_BACK: begin
          if (is_open && depth_zero) begin
            scan_done = 1'b1;
            jump_ip   = sp_r + 1'b1;
          end else begin
            if (is_close) begin
              depth_nxt = depth_r + 1'b1;
            end else if (is_open) begin
              depth_nxt = depth_r - 1'b1;
            end
            // Reaching the first byte without a match resumes at zero.
            if (sp_r == '0) begin
              scan_done = 1'b1;
              jump_ip   = '0;
            end
          end
        end
        default: begin
          scan_done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      prog_mem_r[len_r[ADDR_W-1:0]] <= byte_r;
    end
    rdata_r <= prog_mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_r  <= in_byte;
      value_r <= in_value;
    end
    if (cmd.clr_char) begin
      char_r <= '0;
    end else if (cmd.grab_char) begin
      char_r <= cur_cell[BYTE_W-1:0];
    end
    if (cmd.scan_init) begin
      sa_r    <= scan_start;
      depth_r <= '0;
      skind_r <= cmd.scan_kind;
    end else if (cmd.scan_en) begin
      sp_r    <= sa_r;
      sa_r    <= (skind_r == SCAN_BACK) ? sa_r - 1'b1 : sa_r + 1'b1;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ip_r  <= '0;
      cp_r  <= '0;
      run_r <= 1'b0;
      sv_r  <= 1'b0;
      for (int i = 0; i < TAPE_DEPTH; i++) begin
        tape_r[i] <= '0;
      end
    end else begin
      if (cmd.scan_init) begin
        sv_r <= 1'b0;
      end else if (cmd.scan_en) begin
        sv_r <= 1'b1;
      end

      if (cmd.load_byte) begin
        len_r <= len_r + 1'b1;
      end

      if (cmd.start_run) begin
        run_r <= 1'b1;
      end else if (cmd.clr_run || cmd.load_byte) begin
        run_r <= 1'b0;
      end

      if (cmd.start_run) begin
        ip_r <= '0;
      end else if (cmd.advance) begin
        ip_r <= ip_r + 1'b1;
      end else if (scan_done && skind_r != SCAN_CHECK) begin
        ip_r <= jump_ip;
      end

      if (cmd.start_run) begin
        cp_r <= '0;
        for (int i = 0; i < TAPE_DEPTH; i++) begin
          tape_r[i] <= '0;
        end
      end else if (cmd.exec) begin
        case (instr)
          CLS_INC: tape_r[cp_r] <= cur_cell + 1'b1;
          CLS_DEC: tape_r[cp_r] <= cur_cell - 1'b1;
          CLS_IN:  tape_r[cp_r] <= value_r;
          CLS_RIGHT: begin
            cp_r <= (cp_r == CP_W'(TAPE_DEPTH - 1)) ? '0 : cp_r + 1'b1;
          end
          CLS_LEFT: begin
            cp_r <= (cp_r == '0) ? CP_W'(TAPE_DEPTH - 1) : cp_r - 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    stat.full      = (len_r >= PTR_W'(PROGRAM_DEPTH));
    stat.running   = run_r;
    stat.at_end    = (ip_r >= len_r);
    stat.cell_zero = (cur_cell == '0);
    stat.ip_zero   = (ip_r == '0);
    stat.scan_done = scan_done;
    stat.scan_ok   = scan_ok;
    stat.instr     = instr;
  end

  assign char_out = char_r;
  assign ip_out   = ip_r;

endmodule

// File: rtl/tmi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_ctrl
// Controller: sequences load, start check and instruction execution, and
// holds the status code of the item in flight.
// ----------------------------------------------------------------------------
module tmi_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tmi_pkg::OP_W-1:0]   in_operation,
  input  tmi_pkg::dp_stat_t          stat,
  output tmi_pkg::dp_cmd_t           cmd,
  input  logic                       out_free,
  output logic                       res_load,
  output tmi_pkg::status_t           res_status
);
  import tmi_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_EXEC     = 6'b000100,
    S_CHECK    = 6'b001000,
    S_JUMP     = 6'b010000,
    S_REPLY    = 6'b100000
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  op_t     op_r;
  op_t     op_nxt;
  status_t status_r;
  status_t status_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    status_nxt    = status_r;
    cmd           = '0;
    cmd.scan_kind = SCAN_CHECK;
    in_ready      = 1'b0;
    res_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = op_t'(in_operation);
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        status_nxt   = ST_OK;
        cmd.clr_char = 1'b1;
        state_nxt    = S_REPLY;
        case (op_r)
          OP_LOAD: begin
            if (stat.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.load_byte = 1'b1;
            end
          end
          OP_START: begin
            cmd.scan_init = 1'b1;
            cmd.scan_kind = SCAN_CHECK;
            state_nxt     = S_CHECK;
          end
          OP_STEP: begin
            if (!stat.running) begin
              status_nxt = ST_IDLE;
            end else if (stat.at_end) begin
              status_nxt  = ST_ENDED;
              cmd.clr_run = 1'b1;
            end else begin
              cmd.fetch = 1'b1;
              state_nxt = S_EXEC;
            end
          end
          default: begin
          end
        endcase
      end

      S_EXEC: begin
        state_nxt = S_REPLY;
        case (stat.instr)
          CLS_BAD: begin
            status_nxt  = ST_BADCHAR;
            cmd.clr_run = 1'b1;
          end
          CLS_OPEN: begin
            if (stat.cell_zero) begin
              cmd.scan_init = 1'b1;
              cmd.scan_kind = SCAN_FWD;
              state_nxt     = S_JUMP;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          CLS_CLOSE: begin
            // A backward jump from the first byte has nothing to scan and
            // leaves the counter at zero.
            if (stat.cell_zero) begin
              cmd.advance = 1'b1;
            end else if (!stat.ip_zero) begin
              cmd.scan_init = 1'b1;
              cmd.scan_kind = SCAN_BACK;
              state_nxt     = S_JUMP;
            end
          end
          CLS_OUT: begin
            status_nxt    = ST_CHAR;
            cmd.grab_char = 1'b1;
            cmd.advance   = 1'b1;
          end
          default: begin
            cmd.exec    = 1'b1;
            cmd.advance = 1'b1;
          end
        endcase
      end

      S_CHECK: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_REPLY;
          if (stat.scan_ok) begin
            cmd.start_run = 1'b1;
          end else begin
            status_nxt  = ST_BRACKET;
            cmd.clr_run = 1'b1;
          end
        end
      end

      S_JUMP: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_REPLY;
        end
      end

      S_REPLY: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      op_r     <= OP_LOAD;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      status_r <= status_nxt;
    end
  end

  assign res_status = status_r;

endmodule

// File: rtl/tape_machine_interpreter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_machine_interpreter
// Eight-instruction tape language engine with a byte program store, a word
// tape and one result item per input item.
// ----------------------------------------------------------------------------
// The start check and each bracket jump scan the program byte by byte, since
// the scan reads the single read port of the program store once a cycle.
// One item is in flight at a time; the next item is accepted the cycle after
// the result is loaded into the output register. Reset clears length, the
// instruction and cell pointers, run flag and tape; the program store holds
// no reset value.
module tape_machine_interpreter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tmi_pkg::OP_W-1:0]      in_operation,
  input  logic [tmi_pkg::BYTE_W-1:0]    in_program_byte,
  input  logic signed [tmi_pkg::CELL_W-1:0] in_input_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmi_pkg::STATUS_W-1:0]  out_status,
  output logic [tmi_pkg::BYTE_W-1:0]    out_out_char,
  output logic [tmi_pkg::PC_W-1:0]      out_program_counter
);
  import tmi_pkg::*;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic                res_load;
  status_t             res_status;
  logic [BYTE_W-1:0]   dp_char;
  logic [PTR_W-1:0]    dp_ip;
  logic                out_free;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [BYTE_W-1:0]   out_char_r;
  logic [PC_W-1:0]     out_pc_r;

  assign out_free = !out_valid_r || out_ready;

  tmi_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .out_free     (out_free),
    .res_load     (res_load),
    .res_status   (res_status)
  );

  tmi_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_byte  (in_program_byte),
    .in_value (in_input_value),
    .char_out (dp_char),
    .ip_out   (dp_ip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_char_r   <= dp_char;
      out_pc_r     <= PC_W'(dp_ip);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_out_char        = out_char_r;
  assign out_program_counter = out_pc_r;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the tape machine interpreter. Programs are built from
// segments of the form ",[ body ]" so that a run fed zero input values skips
// every older segment and reaches the newest one. Each accepted item is
// passed through a behavioral interpreter that predicts the result item, and
// the result stream is compared field by field in order. Both handshakes see
// random gaps and stalls. The run closes by filling the program store to
// the brim and stepping through the whole program.
// ----------------------------------------------------------------------------
module tb;
  import tmi_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_ITEMS   = 500;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] pbyte;
    logic [CELL_W-1:0] value;
    logic              drain;
  } pending_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] ch;
    logic [PC_W-1:0]   pc;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = '0;
  logic [BYTE_W-1:0] in_program_byte = '0;
  logic signed [CELL_W-1:0] in_input_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0] out_out_char;
  logic [PC_W-1:0] out_program_counter;

  // Interpreter state as the block should hold it.
  logic [BYTE_W-1:0] code_mem [PROGRAM_DEPTH];
  logic [CELL_W-1:0] tape [TAPE_DEPTH];
  int code_len = 0;
  int exec_pc = 0;
  int head = 0;
  logic active = 1'b0;

  pending_t item_q[$];
  result_t due_results[$];
  logic [BYTE_W-1:0] seg_buf[$];

  int gen_len = 0;
  int n_items = 0;
  int errors = 0;
  int quiet = 0;
  int send_gap = 0;
  int stall_left = 0;
  int calm = 0;
  logic in_took = 1'b0;

  always #5 clk = ~clk;

  tape_machine_interpreter i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_program_byte     (in_program_byte),
    .in_input_value      (in_input_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_out_char        (out_out_char),
    .out_program_counter (out_program_counter)
  );

  task automatic interp_step(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] pbyte,
                             input logic [CELL_W-1:0] val, output result_t r);
    int depth, k, nxt;
    logic bad, found;
    logic [BYTE_W-1:0] c;
    r.status = ST_OK;
    r.ch = '0;
    case (op)
      OP_LOAD: begin
        if (code_len >= PROGRAM_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          code_mem[code_len] = pbyte;
          code_len++;
          active = 1'b0;
        end
      end
      OP_START: begin
        depth = 0;
        bad = 1'b0;
        for (k = 0; k < code_len; k++) begin
          if (code_mem[k] == CH_OPEN) begin
            depth++;
          end else if (code_mem[k] == CH_CLOSE) begin
            if (depth == 0) bad = 1'b1;
            else depth--;
          end
        end
        if (bad || depth != 0) begin
          r.status = ST_BRACKET;
          active = 1'b0;
        end else begin
          for (k = 0; k < TAPE_DEPTH; k++) tape[k] = '0;
          exec_pc = 0;
          head = 0;
          active = 1'b1;
        end
      end
      OP_STEP: begin
        if (!active) begin
          r.status = ST_IDLE;
        end else if (exec_pc >= code_len) begin
          r.status = ST_ENDED;
          active = 1'b0;
        end else begin
          c = code_mem[exec_pc];
          nxt = exec_pc + 1;
          case (c)
            CH_PLUS:  tape[head] = tape[head] + 1;
            CH_MINUS: tape[head] = tape[head] - 1;
            CH_RIGHT: head = (head == TAPE_DEPTH - 1) ? 0 : head + 1;
            CH_LEFT:  head = (head == 0) ? TAPE_DEPTH - 1 : head - 1;
            CH_DOT: begin
              r.status = ST_CHAR;
              r.ch = tape[head][BYTE_W-1:0];
            end
            CH_COMMA: tape[head] = val;
            CH_OPEN: begin
              if (tape[head] == '0) begin
                // Forward scan; without a match the run lands on the end.
                nxt = code_len;
                depth = 0;
                found = 1'b0;
                k = exec_pc + 1;
                while (k < code_len && !found) begin
                  if (code_mem[k] == CH_CLOSE && depth == 0) begin
                    nxt = k + 1;
                    found = 1'b1;
                  end else if (code_mem[k] == CH_OPEN) begin
                    depth++;
                  end else if (code_mem[k] == CH_CLOSE) begin
                    depth--;
                  end
                  k++;
                end
              end
            end
            CH_CLOSE: begin
              if (tape[head] != '0) begin
                // Backward scan; without a match the run resumes at zero.
                nxt = 0;
                depth = 0;
                found = 1'b0;
                k = exec_pc;
                while (k > 0 && !found) begin
                  k--;
                  if (code_mem[k] == CH_OPEN && depth == 0) begin
                    nxt = k + 1;
                    found = 1'b1;
                  end else if (code_mem[k] == CH_CLOSE) begin
                    depth++;
                  end else if (code_mem[k] == CH_OPEN) begin
                    depth--;
                  end
                end
              end
            end
            CH_SPACE: ;
            default: begin
              r.status = ST_BADCHAR;
              active = 1'b0;
              nxt = exec_pc;
            end
          endcase
          exec_pc = nxt;
        end
      end
      default: ;
    endcase
    r.pc = exec_pc[PC_W-1:0];
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CELL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'd1;
      4: return $urandom_range(0, 300);
      default: return $urandom();
    endcase
  endfunction

  task automatic put(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] pbyte,
                     input logic [CELL_W-1:0] value, input logic drain);
    pending_t it;
    it.op = op;
    it.pbyte = pbyte;
    it.value = value;
    it.drain = drain;
    item_q.push_back(it);
    if (op != OP_NONE) n_items++;
    if (op == OP_LOAD && gen_len < PROGRAM_DEPTH) gen_len++;
  endtask

  task automatic put_load(input logic [BYTE_W-1:0] pbyte);
    put(OP_LOAD, pbyte, $urandom(), 1'b0);
  endtask

  task automatic put_step(input logic [CELL_W-1:0] value);
    put(OP_STEP, BYTE_W'($urandom_range(0, 255)), value, 1'b0);
  endtask

  task automatic put_start(input logic drain);
    put(OP_START, BYTE_W'($urandom_range(0, 255)), $urandom(), drain);
  endtask

  task automatic load_segment(input int from, input int upto);
    int k;
    for (k = from; k < upto; k++) put_load(seg_buf[k]);
  endtask

  // Builds ",[" body "]" with balanced brackets in the body. A zero input at
  // the comma makes the whole segment a two-step skip.
  task automatic build_segment(input int body_len);
    int depth, k, pick;
    logic [BYTE_W-1:0] b;
    seg_buf.delete();
    seg_buf.push_back(CH_COMMA);
    seg_buf.push_back(CH_OPEN);
    depth = 0;
    for (k = 0; k < body_len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        seg_buf.push_back(CH_PLUS);
      end else if (pick < 27) begin
        seg_buf.push_back(CH_MINUS);
      end else if (pick < 39) begin
        seg_buf.push_back(CH_RIGHT);
      end else if (pick < 50) begin
        seg_buf.push_back(CH_LEFT);
      end else if (pick < 61) begin
        seg_buf.push_back(CH_DOT);
      end else if (pick < 68) begin
        seg_buf.push_back(CH_COMMA);
      end else if (pick < 72) begin
        seg_buf.push_back(CH_SPACE);
      end else if (pick < 80) begin
        seg_buf.push_back(CH_OPEN);
        depth++;
      end else if (pick < 90 && depth > 0) begin
        seg_buf.push_back(CH_CLOSE);
        depth--;
      end else if (pick < 97) begin
        seg_buf.push_back(CH_OPEN);
        seg_buf.push_back(CH_MINUS);
        seg_buf.push_back(CH_CLOSE);
      end else begin
        b = BYTE_W'($urandom_range(0, 255));
        case (b)
          CH_PLUS, CH_MINUS, CH_RIGHT, CH_LEFT, CH_DOT, CH_COMMA, CH_OPEN, CH_CLOSE,
          CH_SPACE: b = 8'hFF;
          default: ;
        endcase
        seg_buf.push_back(b);
      end
    end
    while (depth > 0) begin
      seg_buf.push_back(CH_CLOSE);
      depth--;
    end
    seg_buf.push_back(CH_CLOSE);
  endtask

  // Sender: one item at a time, held until taken, with random gaps.
  always @(negedge clk) begin
    pending_t it;
    if (rst_n && (!in_valid || in_took)) begin
      in_took = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0 && !(item_q[0].drain && due_results.size() > 0)) begin
        it = item_q.pop_front();
        in_operation <= it.op;
        in_program_byte <= it.pbyte;
        in_input_value <= it.value;
        in_valid <= 1'b1;
        send_gap = (calm > 0) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls; now and then a calm stretch with no idling on either side.
  always @(negedge clk) begin
    if (calm > 0) begin
      calm--;
    end else if ($urandom_range(0, 199) == 0) begin
      calm = $urandom_range(100, 300);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (calm == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      quiet++;
      if (in_valid && in_ready) begin
        interp_step(in_operation, in_program_byte, in_input_value, want);
        due_results.push_back(want);
        in_took = 1'b1;
        quiet = 0;
      end
      if (out_valid && out_ready) begin
        quiet = 0;
        if (due_results.size() == 0) begin
          $display("%0t: result item with none expected, status %0d", $time, out_status);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_status != want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            errors++;
          end
          if (out_out_char != want.ch) begin
            $display("%0t: out_char expected %0h, got %0h", $time, want.ch, out_out_char);
            errors++;
          end
          if (out_program_counter != want.pc) begin
            $display("%0t: program_counter expected %0d, got %0d", $time, want.pc,
                     out_program_counter);
            errors++;
          end
        end
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int top_steps, k, n, split, cut;
    logic noisy, fill_done;

    // Directed opening.
    put_step(32'h0);
    put(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    put_start(1'b0);
    put_step(32'h1);
    put_load(CH_COMMA);
    put_load(CH_OPEN);
    put_start(1'b0);
    put_load(CH_DOT);
    put_load(CH_MINUS);
    put_load(CH_DOT);
    put_load(CH_COMMA);
    put_load(CH_DOT);
    put_load(CH_LEFT);
    put_load(8'hFF);
    put_load(CH_CLOSE);
    put_start(1'b0);
    put_step(32'h7FFF_FFFF);
    put_step(32'h0);
    put_step(32'h0);
    put_step(32'h0);
    put_step(32'h0);
    put_step(32'h8000_0000);
    put_step(32'h0);
    put_step(32'h0);
    put_step(32'h0);
    put_step(32'h0);
    put_start(1'b0);
    put_step(32'h0);
    // A load in the middle of a run stops it.
    put_load(CH_SPACE);
    put_step(32'h0);
    top_steps = 3;

    // Random phases: each adds one segment, walks past the older ones with zero
    // inputs, or random ones in a noisy phase, and then runs the new one with random inputs.
    while (n_items < RANDOM_ITEMS + 30) begin
      build_segment($urandom_range(2, 14));
      if ($urandom_range(0, 5) == 0) begin
        split = $urandom_range(2, seg_buf.size() - 1);
        load_segment(0, split);
        put_start(1'b0);
        put_step(pick_value());
        load_segment(split, seg_buf.size());
      end else begin
        load_segment(0, seg_buf.size());
      end
      if ($urandom_range(0, 3) == 0) begin
        put(OP_NONE, BYTE_W'($urandom_range(0, 255)), $urandom(), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) put_step(pick_value());
      put_start($urandom_range(0, 3) == 0);
      noisy = ($urandom_range(0, 4) == 0);
      for (k = 0; k < top_steps; k++) put_step(noisy ? pick_value() : 32'h0);
      top_steps += 2;
      n = $urandom_range(4, 40);
      cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
      for (k = 0; k < n; k++) begin
        if (k == cut) begin
          put_load(CH_SPACE);
          top_steps++;
        end
        put_step(pick_value());
      end
    end

    // Fill the store, overflow it, then walk the whole program to its end.
    fill_done = 1'b0;
    while (!fill_done) begin
      build_segment($urandom_range(10, 40));
      if (gen_len + seg_buf.size() > PROGRAM_DEPTH) begin
        fill_done = 1'b1;
      end else begin
        load_segment(0, seg_buf.size());
        top_steps += 2;
      end
    end
    while (gen_len < PROGRAM_DEPTH) begin
      put_load(CH_SPACE);
      top_steps++;
    end
    put_load(8'h00);
    put_load(8'hFF);
    put_load(BYTE_W'($urandom_range(0, 255)));
    put_start(1'b1);
    for (k = 0; k < top_steps + 2; k++) put_step(32'h0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (item_q.size() > 0 || in_valid || due_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
